// File: hw/rtl/srt_pkg.sv
// Shared types, codes and constants for the shortest-remaining-time scheduler.
package srt_pkg;

    // Field widths of one request word and one result word.
    localparam int TIME_W      = 16;
    localparam int ID_W        = 8;
    localparam int REM_W       = 10;
    localparam int END_W       = 17;
    localparam int REQ_W       = 2;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 16;

    // Largest remaining time a queue entry can carry.
    localparam logic [REM_W-1:0] REM_MAX = '1;

    // Default number of waiting entries.
    localparam int QUEUE_DEPTH_DEF = 64;

    // Request kinds carried on the input tuser.
    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // One waiting job: identifier and remaining run time.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [REM_W-1:0] rem;
    } entry_t;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0] {
        ALU_END = 2'd0,
        ALU_REM = 2'd1,
        ALU_CMP = 2'd2
    } alu_op_t;

    // Request to the shared arithmetic unit.
    typedef struct packed {
        alu_op_t          op;
        logic [END_W-1:0] a;
        logic [END_W-1:0] b;
        logic             strict;
    } alu_req_t;

    // Answer from the shared arithmetic unit.
    typedef struct packed {
        logic [END_W-1:0] result;
        logic             flag;
    } alu_rsp_t;

endpackage

// File: hw/rtl/shortest_remaining_time_scheduler.sv
// Preemptive shortest-remaining-time scheduler: sequencer, run state and result register.
// Each accepted word passes through dispatch and then the finish step. An add that queues an entry
// first compares keys and inserts by walking down from the tail. A tick that starts a waiting job
// first pops the head entry and shifts the remaining entries up to close the gap.
// One word is in work at a time, since the queue memory's single read port
// and the shared arithmetic unit are each used once per cycle. Reset clears the run state,
// the fill count and the handshakes; the queue memory itself is never cleared.
module shortest_remaining_time_scheduler
    import srt_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // now_time [15:0], job_id [23:16], job_length [33:24], zeros above.
    input  logic [S_TDATA_W-1:0] s_tdata,
    // req_type [1:0].
    input  logic [REQ_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // running_valid [0], running_id [8:1], queue_overflow [9], zeros above.
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [12:0] {
        ST_IDLE      = 13'b0000000000001,
        ST_DISPATCH  = 13'b0000000000010,
        ST_ADD_CMP   = 13'b0000000000100,
        ST_ADD_PRE   = 13'b0000000001000,
        ST_INS_START = 13'b0000000010000,
        ST_INS_RD    = 13'b0000000100000,
        ST_INS_CMP   = 13'b0000001000000,
        ST_POP_RD    = 13'b0000010000000,
        ST_POP_HEAD  = 13'b0000100000000,
        ST_SHIFT_RD  = 13'b0001000000000,
        ST_SHIFT_WR  = 13'b0010000000000,
        ST_FINISH    = 13'b0100000000000,
        ST_SPARE     = 13'b1000000000000
    } state_t;

    state_t               state_reg, state_next;
    logic                 run_valid_reg, run_valid_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 ovf_reg, ovf_next;

    logic [REQ_W-1:0]     req_reg, req_next;
    logic [TIME_W-1:0]    now_reg, now_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [REM_W-1:0]     svc_reg, svc_next;
    logic [ID_W-1:0]      run_id_reg, run_id_next;
    logic [END_W-1:0]     run_end_reg, run_end_next;
    logic [END_W-1:0]     new_end_reg, new_end_next;
    entry_t               ins_reg, ins_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    alu_req_t             alu_req;
    alu_rsp_t             alu_rsp;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    entry_t               mem_wdata;
    logic [AW-1:0]        mem_raddr;
    entry_t               mem_rdata;
    logic [CW-1:0]        idx_ext;
    logic                 run_stays;

    srt_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    srt_queue_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_queue_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign idx_ext   = CW'(idx_reg);
    assign run_stays = run_valid_reg && !alu_rsp.flag;

    // Sequencer: one step of the shared unit and one memory access per cycle.
    always_comb begin
        state_next     = state_reg;
        run_valid_next = run_valid_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        req_next       = req_reg;
        now_next       = now_reg;
        id_next        = id_reg;
        svc_next       = svc_reg;
        run_id_next    = run_id_reg;
        run_end_next   = run_end_reg;
        new_end_next   = new_end_reg;
        ins_next       = ins_reg;
        idx_next       = idx_reg;
        alu_req        = '0;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = ins_reg;
        mem_raddr      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    req_next   = s_tuser;
                    now_next   = s_tdata[15:0];
                    id_next    = s_tdata[23:16];
                    svc_next   = s_tdata[33:24];
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                ovf_next = 1'b0;
                case (req_reg)
                    REQ_ADD: begin
                        alu_req.op   = ALU_END;
                        alu_req.a    = END_W'(now_reg);
                        alu_req.b    = END_W'(svc_reg);
                        new_end_next = alu_rsp.result;
                        if (!run_valid_reg) begin
                            run_valid_next = 1'b1;
                            run_id_next    = id_reg;
                            run_end_next   = alu_rsp.result;
                            state_next     = ST_FINISH;
                        end else begin
                            state_next = ST_ADD_CMP;
                        end
                    end
                    REQ_TICK: begin
                        // Retire the running job once its last quantum has passed.
                        alu_req.op     = ALU_CMP;
                        alu_req.a      = run_end_reg;
                        alu_req.b      = END_W'(now_reg);
                        alu_req.strict = 1'b1;
                        run_valid_next = run_stays;
                        if (!run_stays && count_reg != '0) begin
                            state_next = ST_POP_RD;
                        end else begin
                            state_next = ST_FINISH;
                        end
                    end
                    REQ_CLEAR: begin
                        count_next = '0;
                        state_next = ST_FINISH;
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_ADD_CMP: begin
                // Queue the new job unless it would finish before the running one.
                alu_req.op     = ALU_CMP;
                alu_req.a      = run_end_reg;
                alu_req.b      = new_end_reg;
                alu_req.strict = (svc_reg == '0);
                if (alu_rsp.flag) begin
                    ins_next.id  = id_reg;
                    ins_next.rem = svc_reg;
                    state_next   = ST_INS_START;
                end else begin
                    state_next = ST_ADD_PRE;
                end
            end
            ST_ADD_PRE: begin
                // Preempt: the old job goes back with its remaining time.
                alu_req.op   = ALU_REM;
                alu_req.a    = run_end_reg;
                alu_req.b    = END_W'(now_reg);
                ins_next.id  = run_id_reg;
                ins_next.rem = alu_rsp.result[REM_W-1:0];
                run_id_next  = id_reg;
                run_end_next = new_end_reg;
                state_next   = ST_INS_START;
            end
            ST_INS_START: begin
                if (count_reg == CW'(QUEUE_DEPTH)) begin
                    ovf_next   = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    idx_next   = count_reg[AW-1:0];
                    state_next = ST_INS_RD;
                end
            end
            ST_INS_RD: begin
                // Walk down from the tail; at the head the entry is simply written.
                if (idx_reg == '0) begin
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    mem_wdata  = ins_reg;
                    count_next = count_reg + CW'(1);
                    state_next = ST_FINISH;
                end else begin
                    mem_raddr  = idx_reg - AW'(1);
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                // Larger keys move up one place; equal keys stay ahead of the new entry.
                alu_req.op = ALU_CMP;
                alu_req.a  = END_W'(mem_rdata.rem);
                alu_req.b  = END_W'(ins_reg.rem);
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                if (!alu_rsp.flag) begin
                    mem_wdata  = mem_rdata;
                    idx_next   = idx_reg - AW'(1);
                    state_next = ST_INS_RD;
                end else begin
                    mem_wdata  = ins_reg;
                    count_next = count_reg + CW'(1);
                    state_next = ST_FINISH;
                end
            end
            ST_POP_RD: begin
                mem_raddr  = '0;
                state_next = ST_POP_HEAD;
            end
            ST_POP_HEAD: begin
                // Start the head entry, then close the gap it leaves.
                alu_req.op     = ALU_END;
                alu_req.a      = END_W'(now_reg);
                alu_req.b      = END_W'(mem_rdata.rem);
                run_valid_next = 1'b1;
                run_id_next    = mem_rdata.id;
                run_end_next   = alu_rsp.result;
                idx_next       = '0;
                if (count_reg > CW'(1)) begin
                    state_next = ST_SHIFT_RD;
                end else begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_FINISH;
                end
            end
            ST_SHIFT_RD: begin
                mem_raddr  = idx_reg + AW'(1);
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = mem_rdata;
                if (idx_ext + CW'(2) < count_reg) begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_SHIFT_RD;
                end else begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register: loaded when the sequencer finishes and the slot is free.
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (state_reg == ST_FINISH && (!m_tvalid_reg || m_tready)) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'd0, ovf_reg, run_valid_reg ? run_id_reg : 8'd0, run_valid_reg};
        end
    end

    // Control state with synchronous reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            run_valid_reg <= 1'b0;
            count_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
            ovf_reg       <= 1'b0;
            run_id_reg    <= '0;
            run_end_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            run_valid_reg <= run_valid_next;
            count_reg     <= count_next;
            m_tvalid_reg  <= m_tvalid_next;
            ovf_reg       <= ovf_next;
            run_id_reg    <= run_id_next;
            run_end_reg   <= run_end_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        now_reg     <= now_next;
        id_reg      <= id_next;
        svc_reg     <= svc_next;
        new_end_reg <= new_end_next;
        ins_reg     <= ins_next;
        idx_reg     <= idx_next;
        m_tdata_reg <= m_tdata_next;
    end

    // The fill count never passes the queue depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue fill count above depth");

    // Overflow is only flagged against a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && ovf_reg) |-> count_reg == CW'(QUEUE_DEPTH))
        else $error("overflow flagged with room in the queue");

    // A pop only starts with at least one waiting entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POP_HEAD) |-> count_reg != '0)
        else $error("pop from an empty queue");

    // A clear leaves the queue empty by the time the result is formed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && req_reg == REQ_CLEAR) |-> count_reg == '0)
        else $error("queue not empty after clear");

    // A new result word only appears out of the finish step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result word raised outside the finish step");

endmodule

// File: hw/rtl/srt_alu.sv
// Shared arithmetic unit: end time, recomputed remaining time and key compare.
module srt_alu
    import srt_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [END_W-1:0] rem_m1;
    logic [END_W-1:0] end_sum;
    logic [END_W:0]   diff;
    logic [REM_W-1:0] rem_sat;
    logic             cmp_flag;

    // End time: a plus the remaining time less one, never below a.
    assign rem_m1  = (req.b == '0) ? '0 : req.b - END_W'(1);
    assign end_sum = req.a + rem_m1;

    // Remaining time of a preempted job, clamped to the entry range.
    assign diff = {1'b0, req.a} - {1'b0, req.b} + (END_W+1)'(1);

    always_comb begin
        if (diff[END_W]) begin
            rem_sat = '0;
        end else if (diff > (END_W+1)'(REM_MAX)) begin
            rem_sat = REM_MAX;
        end else begin
            rem_sat = diff[REM_W-1:0];
        end
    end

    // Less than, or less than or equal when the compare is not strict.
    assign cmp_flag = req.strict ? (req.a < req.b) : (req.a <= req.b);

    always_comb begin
        rsp = '0;
        case (req.op)
            ALU_END: begin
                rsp.result = end_sum;
            end
            ALU_REM: begin
                rsp.result = END_W'(rem_sat);
            end
            ALU_CMP: begin
                rsp.flag = cmp_flag;
            end
            default: begin
                rsp = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/srt_queue_mem.sv
// Waiting-queue memory: one write port and one registered read port.
module srt_queue_mem
    import srt_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem_reg [DEPTH];
    entry_t rd_data_reg;

    // Entries hold no reset value; only written entries are ever read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the shortest-remaining-time scheduler: directed table, then random words.
`timescale 1ns / 1ps

module testbench;
    import srt_pkg::*;

    localparam int QUEUE_DEPTH   = QUEUE_DEPTH_DEF;
    // Longest latency of one word plus some margin.
    localparam int SETTLE_CYCLES = 7 + 2 * QUEUE_DEPTH + 16;
    localparam int STALL_LIMIT   = 5000;
    localparam int MAX_REPORTS   = 60;
    localparam int PHASE_WORDS   = 470;

    // The request kind that the block treats as a no-op.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // Traffic mixes of the random part.
    typedef enum int {
        MODE_FILL,
        MODE_MIXED,
        MODE_DRAIN
    } mix_t;

    // One scheduler status word as the block reports it.
    typedef struct packed {
        logic            running;
        logic [ID_W-1:0] id;
        logic            overflow;
    } status_t;

    // One row of the directed table.
    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [TIME_W-1:0] now;
        logic [ID_W-1:0]   id;
        logic [REM_W-1:0]  svc;
        logic              typed;
        status_t           want;
    } plan_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // now_time [15:0], job_id [23:16], job_length [33:24], zeros above.
    logic [S_TDATA_W-1:0] s_tdata;
    // req_type [1:0].
    logic [REQ_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // running_valid [0], running_id [8:1], queue_overflow [9], zeros above.
    logic [M_TDATA_W-1:0] m_tdata;

    int send_idle_pct;
    int recv_idle_pct;
    int error_count;
    int stall_cycles;

    // Status words still owed by the block, oldest first.
    status_t pending_status[$];

    // Mirror of the scheduler: sorted waiting line and the running job.
    entry_t                waiting_jobs[$];
    logic                  run_on;
    logic [ID_W-1:0]       run_job;
    logic [END_W-1:0]      run_last;
    logic [TIME_W-1:0]     clock_now;

    // Directed table: reset state, field extremes, every request kind, preemption,
    // saturation of a large recomputed remaining time, ties and clearing.
    plan_row_t directed_plan [0:19] = '{
        '{REQ_TICK,   16'd0,     8'd0,   10'd0,    1'b1, '{1'b0, 8'd0,   1'b0}},
        '{REQ_UNUSED, 16'd0,     8'd0,   10'd0,    1'b1, '{1'b0, 8'd0,   1'b0}},
        '{REQ_CLEAR,  16'd0,     8'd0,   10'd0,    1'b1, '{1'b0, 8'd0,   1'b0}},
        '{REQ_ADD,    16'd100,   8'd255, 10'd1023, 1'b1, '{1'b1, 8'd255, 1'b0}},
        '{REQ_ADD,    16'd100,   8'd0,   10'd0,    1'b0, '0},
        '{REQ_TICK,   16'd101,   8'd0,   10'd0,    1'b0, '0},
        '{REQ_ADD,    16'd65535, 8'd1,   10'd1023, 1'b0, '0},
        '{REQ_ADD,    16'd0,     8'd2,   10'd1,    1'b0, '0},
        '{REQ_ADD,    16'd0,     8'd3,   10'd1,    1'b0, '0},
        '{REQ_ADD,    16'd0,     8'd4,   10'd1,    1'b0, '0},
        '{REQ_TICK,   16'd1,     8'd0,   10'd0,    1'b0, '0},
        '{REQ_TICK,   16'd1,     8'd0,   10'd0,    1'b0, '0},
        '{REQ_CLEAR,  16'd1,     8'd0,   10'd0,    1'b0, '0},
        '{REQ_TICK,   16'd5,     8'd0,   10'd0,    1'b0, '0},
        '{REQ_UNUSED, 16'd5,     8'd0,   10'd0,    1'b0, '0},
        '{REQ_ADD,    16'd65535, 8'h5A,  10'h2A5,  1'b1, '{1'b1, 8'h5A,  1'b0}},
        '{REQ_ADD,    16'd65535, 8'hA5,  10'h15A,  1'b0, '0},
        '{REQ_TICK,   16'd65535, 8'd0,   10'd0,    1'b0, '0},
        '{REQ_CLEAR,  16'd0,     8'd0,   10'd0,    1'b0, '0},
        '{REQ_TICK,   16'd65535, 8'd0,   10'd0,    1'b0, '0}
    };

    shortest_remaining_time_scheduler #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock, 10 ns period.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Last quantum of a job that starts at now with the given remaining time.
    function automatic logic [END_W-1:0] finish_at(input logic [TIME_W-1:0] now,
                                                   input logic [REM_W-1:0]  rem);
        return END_W'(int'(now) + ((rem != 0) ? int'(rem) - 1 : 0));
    endfunction

    // Stable sorted insert into the waiting line; returns 1 when the entry is dropped.
    function automatic logic enqueue_job(input logic [ID_W-1:0] id, input logic [REM_W-1:0] rem);
        int     pos;
        entry_t job;
        if (waiting_jobs.size() >= QUEUE_DEPTH) return 1'b1;
        pos = 0;
        while (pos < waiting_jobs.size() && waiting_jobs[pos].rem <= rem) pos++;
        job.id  = id;
        job.rem = rem;
        waiting_jobs.insert(pos, job);
        return 1'b0;
    endfunction

    // Advances the mirror by one request and returns the status word it causes.
    function automatic status_t predict_status(input logic [REQ_W-1:0]  req,
                                               input logic [TIME_W-1:0] now,
                                               input logic [ID_W-1:0]   id,
                                               input logic [REM_W-1:0]  svc);
        status_t         status;
        int              limit;
        int              left;
        logic [ID_W-1:0] old_id;
        logic            dropped;
        dropped = 1'b0;
        case (req)
            REQ_ADD: begin
                if (!run_on) begin
                    run_on   = 1'b1;
                    run_job  = id;
                    run_last = finish_at(now, svc);
                end else begin
                    limit = int'(svc) - 1 + int'(now);
                    if (int'(run_last) <= limit) begin
                        dropped = enqueue_job(id, svc);
                    end else begin
                        // Preemption: the old job goes back with what it has left.
                        old_id = run_job;
                        left   = int'(run_last) - int'(now) + 1;
                        if (left > int'(REM_MAX)) left = int'(REM_MAX);
                        if (left < 0) left = 0;
                        run_job  = id;
                        run_last = finish_at(now, svc);
                        dropped  = enqueue_job(old_id, REM_W'(left));
                    end
                end
            end
            REQ_TICK: begin
                if (run_on && run_last < END_W'(now)) run_on = 1'b0;
                if (!run_on && waiting_jobs.size() > 0) begin
                    run_on   = 1'b1;
                    run_job  = waiting_jobs[0].id;
                    run_last = finish_at(now, waiting_jobs[0].rem);
                    void'(waiting_jobs.pop_front());
                end
            end
            REQ_CLEAR: begin
                waiting_jobs.delete();
            end
            default: begin
            end
        endcase
        status.running  = run_on;
        status.id       = run_on ? run_job : '0;
        status.overflow = dropped;
        return status;
    endfunction

    // Counts a mismatch and reports the first few of them.
    task automatic check_field(input string field, input int expected, input int actual);
        if (expected != actual) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, expected, actual);
        end
    endtask

    // Offers one request word, starting and ending at a falling edge.
    task automatic send_word(input logic [REQ_W-1:0]  req,
                             input logic [TIME_W-1:0] now,
                             input logic [ID_W-1:0]   id,
                             input logic [REM_W-1:0]  svc,
                             input logic              typed,
                             input status_t           want);
        status_t forecast;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= S_TDATA_W'({svc, id, now});
        do @(posedge aclk); while (!s_tready);
        forecast = predict_status(req, now, id, svc);
        pending_status.push_back(typed ? want : forecast);
        @(negedge aclk);
    endtask

    // Holds the sender off until every owed word has come, then sets the next idle rates.
    task automatic hold_until_drained(input int next_send, input int next_recv);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_status.size() != 0);
        send_idle_pct = next_send;
        recv_idle_pct = next_recv;
        @(negedge aclk);
    endtask

    // Random traffic in episodes that fill the waiting line, mix, or drain it.
    task automatic random_phase(input int words);
        mix_t             mode;
        int               left_in_mode;
        int               pick;
        int               step_max;
        logic [REQ_W-1:0] req;
        logic [ID_W-1:0]  id;
        logic [REM_W-1:0] svc;
        mode         = MODE_MIXED;
        left_in_mode = 0;
        for (int n = 0; n < words; n++) begin
            if (left_in_mode == 0) begin
                mode         = mix_t'($urandom_range(0, 2));
                left_in_mode = (mode == MODE_FILL) ? $urandom_range(60, 140)
                                                   : $urandom_range(20, 90);
            end
            left_in_mode--;

            // Request kind by the episode's mix.
            pick = $urandom_range(0, 99);
            case (mode)
                MODE_FILL: begin
                    req = (pick < 92) ? REQ_ADD : (pick < 98) ? REQ_TICK :
                          (pick < 99) ? REQ_CLEAR : REQ_UNUSED;
                    step_max = 3;
                end
                MODE_MIXED: begin
                    req = (pick < 45) ? REQ_ADD : (pick < 88) ? REQ_TICK :
                          (pick < 94) ? REQ_CLEAR : REQ_UNUSED;
                    step_max = 12;
                end
                default: begin
                    req = (pick < 15) ? REQ_ADD : (pick < 95) ? REQ_TICK :
                          (pick < 97) ? REQ_CLEAR : REQ_UNUSED;
                    step_max = 80;
                end
            endcase

            // Time mostly moves forward; now and then it jumps anywhere, backward too.
            if ($urandom_range(0, 99) < 3)
                clock_now = TIME_W'($urandom_range(0, 65535));
            else
                clock_now = clock_now + TIME_W'($urandom_range(0, step_max));

            // Mostly short jobs, with some long ones and the extremes.
            pick = $urandom_range(0, 99);
            if (pick < 4)
                svc = pick[0] ? REM_MAX : '0;
            else if (pick < 16)
                svc = REM_W'($urandom_range(0, 1023));
            else
                svc = REM_W'($urandom_range(0, 40));
            id = ID_W'($urandom_range(0, 255));

            if ($urandom_range(0, 199) == 0) hold_until_drained(send_idle_pct, recv_idle_pct);
            send_word(req, clock_now, id, svc, 1'b0, '0);
        end
    endtask

    // Receiver stalls at random.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Compares each result word with the oldest owed status word.
    always @(posedge aclk) begin
        status_t seen;
        status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen.running  = m_tdata[0];
            seen.id       = m_tdata[8:1];
            seen.overflow = m_tdata[9];
            if (pending_status.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: result word with nothing owed, expected none, actual %h",
                             $time, m_tdata);
            end else begin
                want = pending_status.pop_front();
                check_field("running_valid", want.running, seen.running);
                check_field("running_id", want.id, seen.id);
                check_field("queue_overflow", want.overflow, seen.overflow);
            end
        end
    end

    // Watchdog: ends the run when no word moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("shortest_remaining_time_scheduler verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Reset, directed table, three random phases with different idle rates, final check.
    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = REQ_ADD;
        send_idle_pct = 36;
        recv_idle_pct = 48;
        error_count   = 0;
        run_on        = 1'b0;
        run_job       = '0;
        run_last      = '0;
        clock_now     = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_plan[i])
            send_word(directed_plan[i].req, directed_plan[i].now, directed_plan[i].id,
                      directed_plan[i].svc, directed_plan[i].typed, directed_plan[i].want);
        random_phase(PHASE_WORDS - $size(directed_plan));
        hold_until_drained(48, 36);
        random_phase(PHASE_WORDS);
        hold_until_drained(0, 0);
        random_phase(PHASE_WORDS);
        hold_until_drained(0, 0);

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("shortest_remaining_time_scheduler verification clean");
        else
            $display("shortest_remaining_time_scheduler verification failed");
        $finish;
    end

endmodule
